FILE: hw/rtl/ucx_pkg.sv
package ucx_pkg;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
  localparam logic [1:0] REG_INVERT     = 2'd1;
  localparam logic [1:0] REG_STOP       = 2'd2;

  localparam logic [15:0] BIT_PERIOD_RESET = 16'd53;
  localparam logic        INVERT_RESET     = 1'b1;
  localparam logic [1:0]  STOP_RESET       = 2'd2;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_SEND = 2'd1;
  localparam logic [1:0] FUNC_HEX  = 2'd2;

  localparam logic [1:0] TX_IDLE  = 2'd0;
  localparam logic [1:0] TX_START = 2'd1;
  localparam logic [1:0] TX_DATA  = 2'd2;
  localparam logic [1:0] TX_STOP  = 2'd3;

  localparam logic [1:0] RX_IDLE = 2'd0;
  localparam logic [1:0] RX_DATA = 2'd1;
  localparam logic [1:0] RX_STOP = 2'd2;

  localparam logic [7:0] HEX_DIGIT_BASE = 8'h30;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;
  localparam logic [3:0] BYTE_BITS      = 4'd8;

  typedef struct packed {
    logic [15:0] bit_period_ticks;
    logic        invert_line;
    logic [1:0]  stop_periods;
  } cfg_t;

  typedef struct packed {
    logic       send;
    logic       hex;
    logic [7:0] value;
    logic       rxl;
  } cmd_t;

  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       send_refused;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_active;
  } result_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n;
    n = {4'd0, nib};
    return (nib > 4'd9) ? (HEX_ALPHA_BASE + n) : (HEX_DIGIT_BASE + n);
  endfunction

endpackage

FILE: hw/rtl/ucx_if.sv
interface ucx_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] send_value;
  logic       rx_line;

  modport source(output valid, func, send_value, rx_line, input ready);
  modport sink(input valid, func, send_value, rx_line, output ready);
endinterface

interface ucx_result_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       tx_busy;
  logic       send_refused;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       rx_active;

  modport source(output valid, tx_line, tx_busy, send_refused, rx_valid, rx_byte,
                 rx_active, input ready);
  modport sink(input valid, tx_line, tx_busy, send_refused, rx_valid, rx_byte,
               rx_active, output ready);
endinterface

FILE: hw/rtl/inverted_uart_with_hex_send.sv
// channel | dir | handshake     | payload
// item    | in  | valid / ready | func, send_value, rx_line
// result  | out | valid / ready | tx_line, tx_busy, send_refused, rx_valid, rx_byte, rx_active
// apb     | in  | psel, penable | paddr, pwdata, prdata (bit period, invert, stop periods)
//
// one tick request per clock sustained while result is taken; an accepted request is
// held in the two-entry queue and then registered in the result register
// rst is synchronous: uart state idle, config back to 53 ticks, inverted, two stops
// a stalled result holds; the queue keeps taking ticks until both entries fill
module inverted_uart_with_hex_send
  import ucx_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  ucx_item_if.sink              item,
  ucx_result_if.source          result
);

  cfg_t       cfg;
  cmd_t       push_cmd;
  cmd_t       head;
  logic       push;
  logic       q_ready;
  logic       q_valid;
  logic       pop;
  logic [1:0] level;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_period_ticks <= BIT_PERIOD_RESET;
      cfg.invert_line      <= INVERT_RESET;
      cfg.stop_periods     <= STOP_RESET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_BIT_PERIOD: cfg.bit_period_ticks <= pwdata[15:0];
        REG_INVERT:     cfg.invert_line      <= pwdata[0];
        REG_STOP:       cfg.stop_periods     <= pwdata[1:0];
        default:        cfg                  <= cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BIT_PERIOD: prdata = {16'd0, cfg.bit_period_ticks};
      REG_INVERT:     prdata = {31'd0, cfg.invert_line};
      REG_STOP:       prdata = {30'd0, cfg.stop_periods};
      default:        prdata = '0;
    endcase
  end

  ucx_front u_front (
    .item        (item),
    .invert_line (cfg.invert_line),
    .q_ready     (q_ready),
    .push        (push),
    .cmd         (push_cmd)
  );

  ucx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head),
    .level    (level)
  );

  ucx_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .cmd     (head),
    .pop     (pop),
    .result  (result)
  );

`ifndef NO_ASSERTIONS
  a_level_bound : assert property (@(posedge clk) disable iff (rst)
    level != 2'd3)
    else $error("queue level out of range");

  a_push_lands : assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && !pop) |=> (level != 2'd0))
    else $error("accepted request missing from queue");

  a_rx_done_idle : assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.rx_valid) |-> !result.rx_active)
    else $error("receiver still active on completed byte");
`endif

endmodule

FILE: hw/rtl/ucx_front.sv
module ucx_front
  import ucx_pkg::*;
(
  ucx_item_if.sink item,
  input  logic     invert_line,
  input  logic     q_ready,
  output logic     push,
  output cmd_t     cmd
);

  assign item.ready = q_ready;
  assign push       = item.valid && q_ready;

  always_comb begin
    cmd.send  = (item.func == FUNC_SEND) || (item.func == FUNC_HEX);
    cmd.hex   = (item.func == FUNC_HEX);
    cmd.value = item.send_value;
    cmd.rxl   = item.rx_line ^ invert_line;
  end

endmodule

FILE: hw/rtl/ucx_queue.sv
module ucx_queue
  import ucx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cmd_t       push_cmd,
  output logic       ready,
  input  logic       pop,
  output logic       valid,
  output cmd_t       head,
  output logic [1:0] level
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];
  assign level = count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/ucx_back.sv
module ucx_back
  import ucx_pkg::*;
#(
  parameter int DATA_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_valid,
  input  cmd_t cmd,
  output logic pop,
  ucx_result_if.source result
);

  localparam logic [3:0] DB = 4'(DATA_BITS);

  logic [7:0]  tx_shift, tx_shift_next;
  logic [1:0]  tx_phase, tx_phase_next;
  logic [3:0]  tx_bits_left, tx_bits_left_next;
  logic [15:0] tx_timer, tx_timer_next;
  logic [7:0]  hex_pending, hex_pending_next;
  logic        hex_pending_valid, hex_pending_valid_next;
  logic [7:0]  rx_shift, rx_shift_next;
  logic [1:0]  rx_phase, rx_phase_next;
  logic [3:0]  rx_bits_left, rx_bits_left_next;
  logic [16:0] rx_timer, rx_timer_next;

  result_t res, res_next;
  logic    res_valid;
  logic    fire;

  logic [15:0] period;
  logic        busy;
  logic        tx_bit;
  logic [3:0]  tx_idx;
  logic [3:0]  rx_idx;

  assign period = (cfg.bit_period_ticks == 16'd0) ? 16'd1 : cfg.bit_period_ticks;
  assign fire   = q_valid && (!res_valid || result.ready);
  assign pop    = fire;

  always_comb begin
    tx_shift_next          = tx_shift;
    tx_phase_next          = tx_phase;
    tx_bits_left_next      = tx_bits_left;
    tx_timer_next          = tx_timer;
    hex_pending_next       = hex_pending;
    hex_pending_valid_next = hex_pending_valid;
    rx_shift_next          = rx_shift;
    rx_phase_next          = rx_phase;
    rx_bits_left_next      = rx_bits_left;
    rx_timer_next          = rx_timer;
    res_next               = '0;

    // send request
    busy = (tx_phase != TX_IDLE) || hex_pending_valid;
    if (cmd.send) begin
      if (busy) begin
        res_next.send_refused = 1'b1;
      end else begin
        tx_shift_next = cmd.hex ? hex_char(cmd.value[7:4]) : cmd.value;
        tx_phase_next = TX_START;
        tx_timer_next = period;
        if (cmd.hex) begin
          hex_pending_next       = hex_char(cmd.value[3:0]);
          hex_pending_valid_next = 1'b1;
        end
      end
    end

    // line level for this tick
    tx_idx = DB - tx_bits_left_next;
    case (tx_phase_next)
      TX_START: tx_bit = 1'b0;
      TX_DATA:  tx_bit = (tx_idx < BYTE_BITS) ? tx_shift_next[tx_idx[2:0]] : 1'b0;
      default:  tx_bit = 1'b1;
    endcase
    res_next.tx_line = tx_bit ^ cfg.invert_line;

    // transmit timing
    if (tx_phase_next != TX_IDLE) begin
      if (tx_timer_next != 16'd0) begin
        tx_timer_next = tx_timer_next - 16'd1;
      end
      if (tx_timer_next == 16'd0) begin
        tx_timer_next = period;
        case (tx_phase_next)
          TX_START: begin
            tx_phase_next     = TX_DATA;
            tx_bits_left_next = DB;
          end
          TX_DATA: begin
            if (tx_bits_left_next != 4'd0) begin
              tx_bits_left_next = tx_bits_left_next - 4'd1;
            end
            if (tx_bits_left_next == 4'd0) begin
              tx_phase_next     = TX_STOP;
              tx_bits_left_next = (cfg.stop_periods == 2'd0) ? 4'd1
                                                              : {2'd0, cfg.stop_periods};
            end
          end
          default: begin
            if (tx_bits_left_next != 4'd0) begin
              tx_bits_left_next = tx_bits_left_next - 4'd1;
            end
            if (tx_bits_left_next == 4'd0) begin
              if (hex_pending_valid_next) begin
                hex_pending_valid_next = 1'b0;
                tx_shift_next          = hex_pending_next;
                tx_phase_next          = TX_START;
              end else begin
                tx_phase_next = TX_IDLE;
                tx_timer_next = 16'd0;
              end
            end
          end
        endcase
      end
    end

    // receiver
    rx_idx = DB - rx_bits_left;
    if (rx_phase == RX_IDLE) begin
      if (!cmd.rxl) begin
        rx_phase_next     = RX_DATA;
        rx_shift_next     = 8'd0;
        rx_bits_left_next = DB;
        rx_timer_next     = {1'b0, period} + {2'b0, period[15:1]};
      end
    end else begin
      if (rx_timer_next != 17'd0) begin
        rx_timer_next = rx_timer_next - 17'd1;
      end
      if (rx_timer_next == 17'd0) begin
        rx_timer_next = {1'b0, period};
        if (rx_phase == RX_DATA) begin
          if (rx_idx < BYTE_BITS) begin
            rx_shift_next[rx_idx[2:0]] = rx_shift[rx_idx[2:0]] | cmd.rxl;
          end
          if (rx_bits_left_next != 4'd0) begin
            rx_bits_left_next = rx_bits_left_next - 4'd1;
          end
          if (rx_bits_left_next == 4'd0) begin
            rx_phase_next = RX_STOP;
          end
        end else begin
          rx_phase_next     = RX_IDLE;
          rx_timer_next     = 17'd0;
          res_next.rx_valid = 1'b1;
        end
      end
    end

    res_next.tx_busy   = (tx_phase_next != TX_IDLE) || hex_pending_valid_next;
    res_next.rx_byte   = rx_shift_next;
    res_next.rx_active = (rx_phase_next != RX_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift          <= '0;
      tx_phase          <= TX_IDLE;
      tx_bits_left      <= '0;
      tx_timer          <= '0;
      hex_pending       <= '0;
      hex_pending_valid <= 1'b0;
      rx_shift          <= '0;
      rx_phase          <= RX_IDLE;
      rx_bits_left      <= '0;
      rx_timer          <= '0;
      res_valid         <= 1'b0;
    end else begin
      if (fire) begin
        tx_shift          <= tx_shift_next;
        tx_phase          <= tx_phase_next;
        tx_bits_left      <= tx_bits_left_next;
        tx_timer          <= tx_timer_next;
        hex_pending       <= hex_pending_next;
        hex_pending_valid <= hex_pending_valid_next;
        rx_shift          <= rx_shift_next;
        rx_phase          <= rx_phase_next;
        rx_bits_left      <= rx_bits_left_next;
        rx_timer          <= rx_timer_next;
        res_valid         <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.tx_line      = res.tx_line;
  assign result.tx_busy      = res.tx_busy;
  assign result.send_refused = res.send_refused;
  assign result.rx_valid     = res.rx_valid;
  assign result.rx_byte      = res.rx_byte;
  assign result.rx_active    = res.rx_active;

endmodule
